// ===== hdl/htt_pkg.sv =====
// Shared types and constants for the HTML tag tokenizer.
package htt_pkg;

  // Tokenizer states.
  typedef enum logic [4:0] {
    S_DATA, S_AMP, S_LT, S_LT_SLASH, S_TNAME, S_PRE_ANAME, S_ANAME,
    S_POST_ANAME, S_PRE_AVAL, S_AVAL_DQ, S_AVAL_SQ, S_AVAL_UNQ,
    S_POST_AVAL_Q, S_SLASH, S_BANG, S_DT_MATCH, S_DT_BODY, S_SKIP
  } state_t;

  // Event kinds.
  localparam logic [3:0] EV_TEXT    = 4'd0;
  localparam logic [3:0] EV_START   = 4'd1;
  localparam logic [3:0] EV_NAME    = 4'd2;
  localparam logic [3:0] EV_ANAME   = 4'd3;
  localparam logic [3:0] EV_AVAL    = 4'd4;
  localparam logic [3:0] EV_AEND    = 4'd5;
  localparam logic [3:0] EV_ANOVAL  = 4'd6;
  localparam logic [3:0] EV_END     = 4'd7;
  localparam logic [3:0] EV_DOCTYPE = 4'd8;

  // Tag kinds.
  localparam logic [1:0] K_OPEN  = 2'd0;
  localparam logic [1:0] K_CLOSE = 2'd1;
  localparam logic [1:0] K_SELF  = 2'd2;

  // Reset value of the NUL replacement byte.
  localparam logic [7:0] REPL_RESET = 8'd63;

  // Event queue size; the input stage needs room for two words per byte in flight.
  localparam int unsigned EVQ_DEPTH = 8;
  localparam int unsigned EVQ_AW    = $clog2(EVQ_DEPTH);

  // One event as produced by a pass.
  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] ch;
    logic [1:0] tk;
  } ev_t;

  // One event word in the queue.
  typedef struct packed {
    ev_t  ev;
    logic last;
  } qent_t;

  // Result of one tokenizer pass over a byte.
  typedef struct packed {
    state_t     nstate;
    logic [1:0] ntk;
    logic [2:0] nkidx;
    logic       redo;
    logic [1:0] cnt;
    ev_t        ev0;
    ev_t        ev1;
  } pass_t;

endpackage

// ===== hdl/html_tag_tokenizer.sv =====
// Top level of the HTML tag tokenizer: input stage, two tokenizer passes, event queue.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tdata: in_byte
//  out_    | out | out_tvalid/out_tready| tuser: event_kind; tdata: event_char,
//          |     |                      | tag_kind; tlast: last
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_data: replacement_char
//
// A byte is held in the input register and tokenized combinationally from it; its
// words are then written into the event queue, whose head word drives out_.
// A byte is accepted every cycle while the eight-word event queue holds four words or
// fewer; each byte makes zero to two words and the output drains one word per cycle
// while out_tready is high. Reset clears the tokenizer state, the queue and the
// replacement byte (to '?'). Stalls on out_ only fill the queue; in_tready drops once
// it passes four words.
module html_tag_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] event_char, [9:8] tag_kind, [15:10] zero
  output logic [3:0]  out_tuser,   // [3:0] event_kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  htt_pkg::state_t st_r;
  htt_pkg::state_t st_nxt;
  logic [1:0]      tk_r;
  logic [1:0]      tk_nxt;
  logic [2:0]      kidx_r;
  logic [2:0]      kidx_nxt;
  logic [7:0]      repl_r;
  logic [7:0]      byte_r;
  logic            vld_r;
  logic            room;
  htt_pkg::pass_t  p0;
  htt_pkg::pass_t  p1;
  logic [1:0]      push_cnt;
  htt_pkg::ev_t    ea;
  htt_pkg::ev_t    eb;
  logic [1:0]      n_ev;
  htt_pkg::qent_t  push0;
  htt_pkg::qent_t  push1;
  htt_pkg::qent_t  head;

  assign in_tready = room;
  assign cfg_ready = 1'b1;

  // Input register and configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      repl_r <= htt_pkg::REPL_RESET;
    end else begin
      vld_r <= in_tvalid && in_tready;
      if (cfg_valid) repl_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) byte_r <= in_tdata;
  end

  // First pass on the current state, second pass for bytes that are handled again.
  htt_pass u_pass0 (
    .st   (st_r),
    .tk   (tk_r),
    .kidx (kidx_r),
    .b    (byte_r),
    .repl (repl_r),
    .res  (p0)
  );

  htt_pass u_pass1 (
    .st   (p0.nstate),
    .tk   (p0.ntk),
    .kidx (p0.nkidx),
    .b    (byte_r),
    .repl (repl_r),
    .res  (p1)
  );

  // Merge the events of both passes, at most two words per byte.
  always_comb begin
    ea   = p0.ev0;
    eb   = p0.ev1;
    n_ev = p0.cnt;
    if (p0.redo) begin
      unique case (p0.cnt)
        2'd0: begin
          ea   = p1.ev0;
          eb   = p1.ev1;
          n_ev = p1.cnt;
        end
        2'd1: begin
          eb   = p1.ev0;
          n_ev = (p1.cnt != 2'd0) ? 2'd2 : 2'd1;
        end
        default: begin
          n_ev = 2'd2;
        end
      endcase
    end
  end

  always_comb begin
    push0.ev   = ea;
    push0.last = (n_ev == 2'd1);
    push1.ev   = eb;
    push1.last = 1'b1;
    push_cnt   = vld_r ? n_ev : 2'd0;
    if (p0.redo) begin
      st_nxt   = p1.nstate;
      tk_nxt   = p1.ntk;
      kidx_nxt = p1.nkidx;
    end else begin
      st_nxt   = p0.nstate;
      tk_nxt   = p0.ntk;
      kidx_nxt = p0.nkidx;
    end
  end

  // Tokenizer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= htt_pkg::S_DATA;
      tk_r   <= htt_pkg::K_OPEN;
      kidx_r <= 3'd0;
    end else if (vld_r) begin
      st_r   <= st_nxt;
      tk_r   <= tk_nxt;
      kidx_r <= kidx_nxt;
    end
  end

  htt_evq u_evq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (push0),
    .push1     (push1),
    .room      (room),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .head      (head)
  );

  assign out_tdata = {6'd0, head.ev.tk, head.ev.ch};
  assign out_tuser = head.ev.kind;
  assign out_tlast = head.last;

endmodule

// ===== hdl/htt_pass.sv =====
// One pass of the tokenizer state machine over a single byte.
module htt_pass (
  input  htt_pkg::state_t st,
  input  logic [1:0]      tk,
  input  logic [2:0]      kidx,
  input  logic [7:0]      b,
  input  logic [7:0]      repl,
  output htt_pkg::pass_t  res
);

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_SL   = 8'h2F;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_QM   = 8'h3F;
  localparam logic [7:0] CH_DQ   = 8'h22;
  localparam logic [7:0] CH_SQ   = 8'h27;
  localparam logic [7:0] CH_D    = 8'h64;
  localparam logic [2:0] DT_LEN  = 3'd6;

  function automatic htt_pkg::ev_t mk(input logic [3:0] k, input logic [7:0] c,
                                      input logic [1:0] t);
    htt_pkg::ev_t e;
    e.kind = k;
    e.ch   = c;
    e.tk   = t;
    return e;
  endfunction

  // Letters of the doctype keyword after the leading d.
  function automatic logic [7:0] dt_char(input logic [2:0] i);
    logic [7:0] c;
    unique case (i)
      3'd0:    c = 8'h6F;
      3'd1:    c = 8'h63;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h79;
      3'd4:    c = 8'h70;
      3'd5:    c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  logic       ws;
  logic       alpha;
  logic [7:0] lower;
  logic [7:0] name_c;
  logic [7:0] val_c;
  logic [2:0] kidx_inc;

  // Character classes of the current byte.
  assign ws       = (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
  assign alpha    = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  assign lower    = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
  assign name_c   = (b == 8'd0) ? repl : lower;
  assign val_c    = (b == 8'd0) ? repl : b;
  assign kidx_inc = kidx + 3'd1;

  // State transition and event generation.
  always_comb begin
    res        = '0;
    res.nstate = st;
    res.ntk    = tk;
    res.nkidx  = kidx;
    unique case (st)
      htt_pkg::S_DATA: begin
        if (b == CH_AMP) res.nstate = htt_pkg::S_AMP;
        else if (b == CH_LT) res.nstate = htt_pkg::S_LT;
        else begin
          res.ev0 = mk(htt_pkg::EV_TEXT, b, htt_pkg::K_OPEN);
          res.cnt = 2'd1;
        end
      end
      htt_pkg::S_AMP: begin
        res.ev0    = mk(htt_pkg::EV_TEXT, CH_AMP, htt_pkg::K_OPEN);
        res.ev1    = mk(htt_pkg::EV_TEXT, b, htt_pkg::K_OPEN);
        res.cnt    = 2'd2;
        res.nstate = htt_pkg::S_DATA;
      end
      htt_pkg::S_LT: begin
        if (alpha) begin
          res.ntk    = htt_pkg::K_OPEN;
          res.ev0    = mk(htt_pkg::EV_START, 8'd0, htt_pkg::K_OPEN);
          res.ev1    = mk(htt_pkg::EV_NAME, lower, htt_pkg::K_OPEN);
          res.cnt    = 2'd2;
          res.nstate = htt_pkg::S_TNAME;
        end else if (b == CH_BANG) res.nstate = htt_pkg::S_BANG;
        else if (b == CH_SL) res.nstate = htt_pkg::S_LT_SLASH;
        else if (b == CH_QM) res.nstate = htt_pkg::S_SKIP;
        else begin
          // Stray less-than: emit it as text and run the byte again as text.
          res.ev0    = mk(htt_pkg::EV_TEXT, CH_LT, htt_pkg::K_OPEN);
          res.cnt    = 2'd1;
          res.nstate = htt_pkg::S_DATA;
          res.redo   = 1'b1;
        end
      end
      htt_pkg::S_LT_SLASH: begin
        if (alpha) begin
          res.ntk    = htt_pkg::K_CLOSE;
          res.ev0    = mk(htt_pkg::EV_START, 8'd0, htt_pkg::K_CLOSE);
          res.ev1    = mk(htt_pkg::EV_NAME, lower, htt_pkg::K_OPEN);
          res.cnt    = 2'd2;
          res.nstate = htt_pkg::S_TNAME;
        end else if (b == CH_GT) res.nstate = htt_pkg::S_DATA;
        else res.nstate = htt_pkg::S_SKIP;
      end
      htt_pkg::S_TNAME: begin
        if (ws) res.nstate = htt_pkg::S_PRE_ANAME;
        else if (b == CH_SL) res.nstate = htt_pkg::S_SLASH;
        else if (b == CH_GT) begin
          res.ev0    = mk(htt_pkg::EV_END, 8'd0, tk);
          res.cnt    = 2'd1;
          res.nstate = htt_pkg::S_DATA;
        end else begin
          res.ev0 = mk(htt_pkg::EV_NAME, name_c, htt_pkg::K_OPEN);
          res.cnt = 2'd1;
        end
      end
      htt_pkg::S_PRE_ANAME: begin
        if (ws) res.nstate = htt_pkg::S_PRE_ANAME;
        else if (b == CH_SL) res.nstate = htt_pkg::S_SLASH;
        else if (b == CH_GT) begin
          res.ev0    = mk(htt_pkg::EV_END, 8'd0, tk);
          res.cnt    = 2'd1;
          res.nstate = htt_pkg::S_DATA;
        end else begin
          res.ev0    = mk(htt_pkg::EV_ANAME, name_c, htt_pkg::K_OPEN);
          res.cnt    = 2'd1;
          res.nstate = htt_pkg::S_ANAME;
        end
      end
      htt_pkg::S_ANAME: begin
        if (ws) res.nstate = htt_pkg::S_POST_ANAME;
        else if (b == CH_SL) begin
          res.ev0    = mk(htt_pkg::EV_ANOVAL, 8'd0, htt_pkg::K_OPEN);
          res.cnt    = 2'd1;
          res.nstate = htt_pkg::S_SLASH;
        end else if (b == CH_EQ) res.nstate = htt_pkg::S_PRE_AVAL;
        else if (b == CH_GT) begin
          res.ev0    = mk(htt_pkg::EV_ANOVAL, 8'd0, htt_pkg::K_OPEN);
          res.ev1    = mk(htt_pkg::EV_END, 8'd0, tk);
          res.cnt    = 2'd2;
          res.nstate = htt_pkg::S_DATA;
        end else begin
          res.ev0 = mk(htt_pkg::EV_ANAME, name_c, htt_pkg::K_OPEN);
          res.cnt = 2'd1;
        end
      end
      htt_pkg::S_POST_ANAME: begin
        if (ws) res.nstate = htt_pkg::S_POST_ANAME;
        else if (b == CH_EQ) res.nstate = htt_pkg::S_PRE_AVAL;
        else begin
          // Any other byte closes the attribute without a value first.
          res.ev0 = mk(htt_pkg::EV_ANOVAL, 8'd0, htt_pkg::K_OPEN);
          res.cnt = 2'd1;
          if (b == CH_SL) res.nstate = htt_pkg::S_SLASH;
          else if (b == CH_GT) begin
            res.ev1    = mk(htt_pkg::EV_END, 8'd0, tk);
            res.cnt    = 2'd2;
            res.nstate = htt_pkg::S_DATA;
          end else begin
            res.ev1    = mk(htt_pkg::EV_ANAME, name_c, htt_pkg::K_OPEN);
            res.cnt    = 2'd2;
            res.nstate = htt_pkg::S_ANAME;
          end
        end
      end
      htt_pkg::S_PRE_AVAL: begin
        if (ws) res.nstate = htt_pkg::S_PRE_AVAL;
        else if (b == CH_DQ) res.nstate = htt_pkg::S_AVAL_DQ;
        else if (b == CH_SQ) res.nstate = htt_pkg::S_AVAL_SQ;
        else if (b == CH_GT) begin
          res.ev0    = mk(htt_pkg::EV_ANOVAL, 8'd0, htt_pkg::K_OPEN);
          res.ev1    = mk(htt_pkg::EV_END, 8'd0, tk);
          res.cnt    = 2'd2;
          res.nstate = htt_pkg::S_DATA;
        end else begin
          res.ev0    = mk(htt_pkg::EV_AVAL, val_c, htt_pkg::K_OPEN);
          res.cnt    = 2'd1;
          res.nstate = htt_pkg::S_AVAL_UNQ;
        end
      end
      htt_pkg::S_AVAL_DQ: begin
        if (b == CH_DQ) res.nstate = htt_pkg::S_POST_AVAL_Q;
        else begin
          res.ev0 = mk(htt_pkg::EV_AVAL, val_c, htt_pkg::K_OPEN);
          res.cnt = 2'd1;
        end
      end
      htt_pkg::S_AVAL_SQ: begin
        if (b == CH_SQ) res.nstate = htt_pkg::S_POST_AVAL_Q;
        else begin
          res.ev0 = mk(htt_pkg::EV_AVAL, val_c, htt_pkg::K_OPEN);
          res.cnt = 2'd1;
        end
      end
      htt_pkg::S_AVAL_UNQ: begin
        if (ws) begin
          res.ev0    = mk(htt_pkg::EV_AEND, 8'd0, htt_pkg::K_OPEN);
          res.cnt    = 2'd1;
          res.nstate = htt_pkg::S_PRE_ANAME;
        end else if (b == CH_GT) begin
          res.ev0    = mk(htt_pkg::EV_AEND, 8'd0, htt_pkg::K_OPEN);
          res.ev1    = mk(htt_pkg::EV_END, 8'd0, tk);
          res.cnt    = 2'd2;
          res.nstate = htt_pkg::S_DATA;
        end else begin
          res.ev0 = mk(htt_pkg::EV_AVAL, val_c, htt_pkg::K_OPEN);
          res.cnt = 2'd1;
        end
      end
      htt_pkg::S_POST_AVAL_Q: begin
        res.ev0 = mk(htt_pkg::EV_AEND, 8'd0, htt_pkg::K_OPEN);
        res.cnt = 2'd1;
        if (ws) res.nstate = htt_pkg::S_PRE_ANAME;
        else if (b == CH_SL) res.nstate = htt_pkg::S_SLASH;
        else if (b == CH_GT) begin
          res.ev1    = mk(htt_pkg::EV_END, 8'd0, tk);
          res.cnt    = 2'd2;
          res.nstate = htt_pkg::S_DATA;
        end else begin
          res.nstate = htt_pkg::S_PRE_ANAME;
          res.redo   = 1'b1;
        end
      end
      htt_pkg::S_SLASH: begin
        if (b == CH_GT) begin
          res.ntk    = htt_pkg::K_SELF;
          res.ev0    = mk(htt_pkg::EV_END, 8'd0, htt_pkg::K_SELF);
          res.cnt    = 2'd1;
          res.nstate = htt_pkg::S_DATA;
        end else begin
          res.nstate = htt_pkg::S_PRE_ANAME;
          res.redo   = 1'b1;
        end
      end
      htt_pkg::S_BANG: begin
        if (lower == CH_D) begin
          res.nkidx  = 3'd0;
          res.nstate = htt_pkg::S_DT_MATCH;
        end else if (b == CH_GT) res.nstate = htt_pkg::S_DATA;
        else res.nstate = htt_pkg::S_SKIP;
      end
      htt_pkg::S_DT_MATCH: begin
        if (kidx < DT_LEN && lower == dt_char(kidx)) begin
          if (kidx_inc >= DT_LEN) begin
            res.nkidx  = 3'd0;
            res.nstate = htt_pkg::S_DT_BODY;
          end else begin
            res.nkidx = kidx_inc;
          end
        end else begin
          // Mismatch: this byte starts the skip to the closing bracket.
          res.nkidx  = 3'd0;
          res.nstate = htt_pkg::S_SKIP;
          res.redo   = 1'b1;
        end
      end
      htt_pkg::S_DT_BODY: begin
        if (b == CH_GT) begin
          res.ev0    = mk(htt_pkg::EV_DOCTYPE, 8'd0, htt_pkg::K_OPEN);
          res.cnt    = 2'd1;
          res.nstate = htt_pkg::S_DATA;
        end
      end
      htt_pkg::S_SKIP: begin
        if (b == CH_GT) res.nstate = htt_pkg::S_DATA;
      end
      default: begin
        res.nstate = htt_pkg::S_DATA;
        res.redo   = 1'b1;
      end
    endcase
  end

endmodule

// ===== hdl/htt_evq.sv =====
// Event queue between the tokenizer step and the result channel.
module htt_evq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_cnt,
  input  htt_pkg::qent_t    push0,
  input  htt_pkg::qent_t    push1,
  output logic              room,
  output logic              pop_valid,
  input  logic              pop_ready,
  output htt_pkg::qent_t    head
);

  localparam int unsigned AW = htt_pkg::EVQ_AW;
  localparam int unsigned CW = AW + 1;

  htt_pkg::qent_t mem_r [htt_pkg::EVQ_DEPTH];
  logic [AW-1:0]  wr_r;
  logic [AW-1:0]  wr_nxt;
  logic [AW-1:0]  rd_r;
  logic [AW-1:0]  rd_nxt;
  logic [CW-1:0]  cnt_r;
  logic [CW-1:0]  cnt_nxt;
  logic           pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (cnt_r != '0);
  assign head      = mem_r[rd_r];
  // Room for two words from the byte in the input stage and two from a new byte.
  assign room      = (cnt_r <= CW'(htt_pkg::EVQ_DEPTH - 4));

  // Pointer and fill count updates.
  always_comb begin
    wr_nxt  = wr_r + AW'(push_cnt);
    rd_nxt  = rd_r + AW'(pop);
    cnt_nxt = cnt_r + CW'(push_cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage writes, up to two words per cycle.
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wr_r] <= push0;
    if (push_cnt == 2'd2) mem_r[wr_r + AW'(1)] <= push1;
  end

endmodule

// ===== hdl/htt_chk.sv =====
// Port-level checks for the HTML tag tokenizer, bound to the top level.
module htt_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [3:0]  out_tuser,
  input logic        out_tlast
);

  // Reset empties the event queue.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // A stalled word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output word changed");

  // Only defined event kinds are produced.
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= htt_pkg::EV_DOCTYPE)
    else $error("undefined event kind");

  // Tag kind is set only on tag start and tag end, and never to the unused code.
  a_tag_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[9:8] <= htt_pkg::K_SELF) &&
      (out_tdata[9:8] == htt_pkg::K_OPEN || out_tuser == htt_pkg::EV_START ||
       out_tuser == htt_pkg::EV_END))
    else $error("tag kind on wrong event");

  // Structural events carry no character.
  a_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == htt_pkg::EV_START || out_tuser == htt_pkg::EV_AEND ||
      out_tuser == htt_pkg::EV_ANOVAL || out_tuser == htt_pkg::EV_END ||
      out_tuser == htt_pkg::EV_DOCTYPE) |-> out_tdata[7:0] == 8'd0)
    else $error("character on structural event");

endmodule

bind html_tag_tokenizer htt_chk u_htt_chk (.*);

// ===== test/htt_event_checker.sv =====
// Event checker for the HTML tag tokenizer: predicts the event words of each accepted byte.
module htt_event_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,   // [7:0] event_char, [9:8] tag_kind, [15:10] zero
  input  logic [3:0]  out_tuser,   // [3:0] event_kind
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output int          err_count,
  output int          pending_count
);

  // Byte codes the tokenizer reacts to.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_LOW_D = 8'h64;
  localparam logic [7:0] CH_NONE  = 8'h00;
  localparam logic [1:0] TK_NONE  = 2'd0;
  // Rest of the doctype keyword after the 'd', first letter in the top byte.
  localparam logic [47:0] DT_WORD = "octype";
  localparam int         DT_LEN   = 6;

  // Predicted tokenizer state and register copy.
  htt_pkg::state_t tok_state;
  logic [1:0]      tok_tag_kind;
  logic [2:0]      kw_idx;
  logic [7:0]      repl_char;
  htt_pkg::ev_t    byte_events[$];
  htt_pkg::qent_t  predicted_events[$];

  function automatic bit is_ws(logic [7:0] b);
    return b == CH_SPACE || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic bit is_alpha(logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

  function automatic logic [7:0] name_char(logic [7:0] b);
    return b == CH_NUL ? repl_char : to_lower(b);
  endfunction

  function automatic logic [7:0] value_char(logic [7:0] b);
    return b == CH_NUL ? repl_char : b;
  endfunction

  // A byte never yields more than two events.
  function automatic void add_event(logic [3:0] kind, logic [7:0] ch, logic [1:0] tk);
    htt_pkg::ev_t e;
    e.kind = kind;
    e.ch   = ch;
    e.tk   = tk;
    if (byte_events.size() < 2) byte_events.push_back(e);
  endfunction

  function automatic void close_tag();
    add_event(htt_pkg::EV_END, CH_NONE, tok_tag_kind);
    tok_state = htt_pkg::S_DATA;
  endfunction

  // One pass over a byte; returns 1 when the byte must be taken again in the new state.
  function automatic bit tokenize_pass(logic [7:0] b);
    bit redo;
    redo = 1'b0;
    case (tok_state)
      htt_pkg::S_DATA: begin
        if (b == CH_AMP) tok_state = htt_pkg::S_AMP;
        else if (b == CH_LT) tok_state = htt_pkg::S_LT;
        else add_event(htt_pkg::EV_TEXT, b, TK_NONE);
      end
      htt_pkg::S_AMP: begin
        add_event(htt_pkg::EV_TEXT, CH_AMP, TK_NONE);
        add_event(htt_pkg::EV_TEXT, b, TK_NONE);
        tok_state = htt_pkg::S_DATA;
      end
      htt_pkg::S_LT: begin
        if (is_alpha(b)) begin
          tok_tag_kind = htt_pkg::K_OPEN;
          add_event(htt_pkg::EV_START, CH_NONE, htt_pkg::K_OPEN);
          add_event(htt_pkg::EV_NAME, to_lower(b), TK_NONE);
          tok_state = htt_pkg::S_TNAME;
        end else if (b == CH_BANG) tok_state = htt_pkg::S_BANG;
        else if (b == CH_SLASH) tok_state = htt_pkg::S_LT_SLASH;
        else if (b == CH_QMARK) tok_state = htt_pkg::S_SKIP;
        else begin
          // Stray less-than: emit it as text and reread the byte as text.
          add_event(htt_pkg::EV_TEXT, CH_LT, TK_NONE);
          tok_state = htt_pkg::S_DATA;
          redo = 1'b1;
        end
      end
      htt_pkg::S_LT_SLASH: begin
        if (is_alpha(b)) begin
          tok_tag_kind = htt_pkg::K_CLOSE;
          add_event(htt_pkg::EV_START, CH_NONE, htt_pkg::K_CLOSE);
          add_event(htt_pkg::EV_NAME, to_lower(b), TK_NONE);
          tok_state = htt_pkg::S_TNAME;
        end else if (b == CH_GT) tok_state = htt_pkg::S_DATA;
        else tok_state = htt_pkg::S_SKIP;
      end
      htt_pkg::S_TNAME: begin
        if (is_ws(b)) tok_state = htt_pkg::S_PRE_ANAME;
        else if (b == CH_SLASH) tok_state = htt_pkg::S_SLASH;
        else if (b == CH_GT) close_tag();
        else add_event(htt_pkg::EV_NAME, name_char(b), TK_NONE);
      end
      htt_pkg::S_PRE_ANAME: begin
        if (is_ws(b)) begin
        end else if (b == CH_SLASH) tok_state = htt_pkg::S_SLASH;
        else if (b == CH_GT) close_tag();
        else begin
          add_event(htt_pkg::EV_ANAME, name_char(b), TK_NONE);
          tok_state = htt_pkg::S_ANAME;
        end
      end
      htt_pkg::S_ANAME: begin
        if (is_ws(b)) tok_state = htt_pkg::S_POST_ANAME;
        else if (b == CH_SLASH) begin
          add_event(htt_pkg::EV_ANOVAL, CH_NONE, TK_NONE);
          tok_state = htt_pkg::S_SLASH;
        end else if (b == CH_EQ) tok_state = htt_pkg::S_PRE_AVAL;
        else if (b == CH_GT) begin
          add_event(htt_pkg::EV_ANOVAL, CH_NONE, TK_NONE);
          close_tag();
        end else add_event(htt_pkg::EV_ANAME, name_char(b), TK_NONE);
      end
      htt_pkg::S_POST_ANAME: begin
        if (is_ws(b)) begin
        end else if (b == CH_EQ) tok_state = htt_pkg::S_PRE_AVAL;
        else begin
          add_event(htt_pkg::EV_ANOVAL, CH_NONE, TK_NONE);
          if (b == CH_SLASH) tok_state = htt_pkg::S_SLASH;
          else if (b == CH_GT) close_tag();
          else begin
            add_event(htt_pkg::EV_ANAME, name_char(b), TK_NONE);
            tok_state = htt_pkg::S_ANAME;
          end
        end
      end
      htt_pkg::S_PRE_AVAL: begin
        if (is_ws(b)) begin
        end else if (b == CH_DQ) tok_state = htt_pkg::S_AVAL_DQ;
        else if (b == CH_SQ) tok_state = htt_pkg::S_AVAL_SQ;
        else if (b == CH_GT) begin
          // Equals directly before the bracket: the attribute has no value.
          add_event(htt_pkg::EV_ANOVAL, CH_NONE, TK_NONE);
          close_tag();
        end else begin
          add_event(htt_pkg::EV_AVAL, value_char(b), TK_NONE);
          tok_state = htt_pkg::S_AVAL_UNQ;
        end
      end
      htt_pkg::S_AVAL_DQ: begin
        if (b == CH_DQ) tok_state = htt_pkg::S_POST_AVAL_Q;
        else add_event(htt_pkg::EV_AVAL, value_char(b), TK_NONE);
      end
      htt_pkg::S_AVAL_SQ: begin
        if (b == CH_SQ) tok_state = htt_pkg::S_POST_AVAL_Q;
        else add_event(htt_pkg::EV_AVAL, value_char(b), TK_NONE);
      end
      htt_pkg::S_AVAL_UNQ: begin
        if (is_ws(b)) begin
          add_event(htt_pkg::EV_AEND, CH_NONE, TK_NONE);
          tok_state = htt_pkg::S_PRE_ANAME;
        end else if (b == CH_GT) begin
          add_event(htt_pkg::EV_AEND, CH_NONE, TK_NONE);
          close_tag();
        end else add_event(htt_pkg::EV_AVAL, value_char(b), TK_NONE);
      end
      htt_pkg::S_POST_AVAL_Q: begin
        add_event(htt_pkg::EV_AEND, CH_NONE, TK_NONE);
        if (is_ws(b)) tok_state = htt_pkg::S_PRE_ANAME;
        else if (b == CH_SLASH) tok_state = htt_pkg::S_SLASH;
        else if (b == CH_GT) close_tag();
        else begin
          tok_state = htt_pkg::S_PRE_ANAME;
          redo = 1'b1;
        end
      end
      htt_pkg::S_SLASH: begin
        // Only a slash right before the bracket marks a self-closing tag.
        if (b == CH_GT) begin
          tok_tag_kind = htt_pkg::K_SELF;
          close_tag();
        end else begin
          tok_state = htt_pkg::S_PRE_ANAME;
          redo = 1'b1;
        end
      end
      htt_pkg::S_BANG: begin
        if (to_lower(b) == CH_LOW_D) begin
          kw_idx = 3'd0;
          tok_state = htt_pkg::S_DT_MATCH;
        end else if (b == CH_GT) tok_state = htt_pkg::S_DATA;
        else tok_state = htt_pkg::S_SKIP;
      end
      htt_pkg::S_DT_MATCH: begin
        if (int'(kw_idx) < DT_LEN &&
            to_lower(b) == DT_WORD[47 - 8 * int'(kw_idx) -: 8]) begin
          kw_idx = kw_idx + 3'd1;
          if (int'(kw_idx) >= DT_LEN) begin
            kw_idx = 3'd0;
            tok_state = htt_pkg::S_DT_BODY;
          end
        end else begin
          // A keyword mismatch turns into a skip that starts at this byte.
          kw_idx = 3'd0;
          tok_state = htt_pkg::S_SKIP;
          redo = 1'b1;
        end
      end
      htt_pkg::S_DT_BODY: begin
        if (b == CH_GT) begin
          add_event(htt_pkg::EV_DOCTYPE, CH_NONE, TK_NONE);
          tok_state = htt_pkg::S_DATA;
        end
      end
      htt_pkg::S_SKIP: begin
        if (b == CH_GT) tok_state = htt_pkg::S_DATA;
      end
      default: begin
        tok_state = htt_pkg::S_DATA;
        redo = 1'b1;
      end
    endcase
    return redo;
  endfunction

  // Tokenizes one accepted byte and queues its event words, last flag on the final one.
  task automatic tokenize_byte(input logic [7:0] b);
    htt_pkg::qent_t w;
    int             p;
    byte_events.delete();
    for (p = 0; p < 3; p++) begin
      if (!tokenize_pass(b)) break;
    end
    for (p = 0; p < byte_events.size(); p++) begin
      w.ev   = byte_events[p];
      w.last = (p == byte_events.size() - 1);
      predicted_events.push_back(w);
    end
  endtask

  // Compare output words, then predict input bytes, then track register writes.
  always @(posedge clk) begin
    htt_pkg::qent_t got;
    htt_pkg::qent_t want;
    if (!rst_n) begin
      tok_state     = htt_pkg::S_DATA;
      tok_tag_kind  = htt_pkg::K_OPEN;
      kw_idx        = 3'd0;
      repl_char     = htt_pkg::REPL_RESET;
      predicted_events.delete();
      err_count     = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.ev.kind = out_tuser;
        got.ev.ch   = out_tdata[7:0];
        got.ev.tk   = out_tdata[9:8];
        got.last    = out_tlast;
        if (predicted_events.size() == 0) begin
          err_count++;
          $display({"%0t: unexpected word: expected none, got kind %0d char %02h ",
                    "tag_kind %0d last %0b"},
                   $time, got.ev.kind, got.ev.ch, got.ev.tk, got.last);
        end else begin
          want = predicted_events.pop_front();
          if (got !== want || out_tdata[15:10] !== 6'd0) begin
            err_count++;
            $display({"%0t: word mismatch: expected kind %0d char %02h tag_kind %0d ",
                      "last %0b, got kind %0d char %02h tag_kind %0d last %0b pad %02h"},
                     $time, want.ev.kind, want.ev.ch, want.ev.tk, want.last,
                     got.ev.kind, got.ev.ch, got.ev.tk, got.last, out_tdata[15:10]);
          end
        end
      end
      if (in_tvalid && in_tready) tokenize_byte(in_tdata);
      if (cfg_valid && cfg_ready) repl_char = cfg_data;
    end
    pending_count = predicted_events.size();
  end

endmodule

// ===== test/html_tag_tokenizer_tb.sv =====
// Testbench top for the HTML tag tokenizer: byte stimulus, output back-pressure and verdict.
module html_tag_tokenizer_tb;

  localparam int PHASE_BYTES     = 140;
  localparam int NUM_PHASES      = 4;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 20;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam logic [7:0] CH_NUL = 8'h00;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] in_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;   // [7:0] event_char, [9:8] tag_kind, [15:10] zero
  logic [3:0]  out_tuser;   // [3:0] event_kind
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  int          err_count;
  int          pending_count;

  bit          quiet;       // no idling on either side
  int          gap_odds;    // one input gap per this many bytes; 0 means none
  int          bytes_sent;
  int          stall_left;
  int          idle_cycles;

  html_tag_tokenizer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  htt_event_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .err_count    (err_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output back-pressure: random stall bursts, none in the quiet part.
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (quiet) out_tready = 1'b1;
      else if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 7) == 0) begin
        out_tready = 1'b0;
        stall_left = $urandom_range(1, 18) - 1;
      end else out_tready = 1'b1;
    end
  end

  // Watchdog on cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Sends one byte, optionally after a random gap; valid stays high between bytes.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (!quiet && gap_odds > 0 && $urandom_range(0, gap_odds - 1) == 0)
      gap = $urandom_range(1, 18);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Waits until every predicted word has arrived and bytes without events have cleared.
  task automatic settle();
    in_tvalid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_repl(input logic [7:0] v);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [7:0] rand_ws();
    int r;
    r = $urandom_range(0, 6);
    return r == 6 ? 8'd32 : 8'(9 + r);
  endfunction

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
  endfunction

  // Mostly letters, now and then a NUL or any byte at all.
  function automatic logic [7:0] rand_name_char();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return CH_NUL;
    if (r == 1) return 8'($urandom_range(0, 255));
    return rand_letter();
  endfunction

  // Any byte except the one given, which ends the run it sits in.
  function automatic logic [7:0] rand_body_char(input logic [7:0] stop);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return b == stop ? 8'h2E : b;
  endfunction

  // One random tag with up to three attributes of every value form.
  task automatic send_rand_tag();
    int n;
    int a;
    int i;
    int form;
    logic [7:0] q;
    send_byte("<");
    if ($urandom_range(0, 3) == 0) send_byte("/");
    send_byte(rand_letter());
    n = $urandom_range(0, 4);
    for (i = 0; i < n; i++) send_byte(rand_name_char());
    n = $urandom_range(0, 3);
    for (a = 0; a < n; a++) begin
      send_byte(rand_ws());
      if ($urandom_range(0, 3) == 0) send_byte(rand_ws());
      send_byte(rand_letter());
      form = $urandom_range(0, 3);
      for (i = $urandom_range(0, 2); i > 0; i--) send_byte(rand_name_char());
      if (form == 0) continue;
      if ($urandom_range(0, 3) == 0) send_byte(rand_ws());
      send_byte("=");
      if ($urandom_range(0, 3) == 0) send_byte(rand_ws());
      if (form == 1) begin
        send_byte(rand_letter());
        for (i = $urandom_range(0, 3); i > 0; i--) send_byte(rand_name_char());
      end else begin
        q = form == 2 ? 8'h22 : 8'h27;
        send_byte(q);
        for (i = $urandom_range(0, 4); i > 0; i--) send_byte(rand_body_char(q));
        send_byte(q);
      end
    end
    if ($urandom_range(0, 3) == 0) send_byte(rand_ws());
    if ($urandom_range(0, 4) == 0) send_byte("/");
    send_byte(">");
  endtask

  // A random piece of document: tags most often, also text, skipped markup, doctype, noise.
  task automatic send_fragment();
    int r;
    int i;
    int bad;
    string dt;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: gap_odds = 0;
      1: gap_odds = 3;
      default: gap_odds = 12;
    endcase
    if (r < 45) send_rand_tag();
    else if (r < 65) begin
      for (i = $urandom_range(1, 8); i > 0; i--) begin
        if ($urandom_range(0, 7) == 0) send_byte("&");
        send_byte($urandom_range(0, 3) == 0 ? rand_ws() : rand_name_char());
      end
    end else if (r < 73) begin
      case ($urandom_range(0, 3))
        0: send_str("<!--");
        1: send_str("<?");
        2: send_str("<![CDATA[");
        default: send_str("</ ");
      endcase
      for (i = $urandom_range(0, 5); i > 0; i--) send_byte(rand_body_char(">"));
      send_byte(">");
    end else if (r < 82) begin
      dt = "doctype";
      bad = $urandom_range(0, 3) == 0 ? $urandom_range(0, 6) : -1;
      send_byte("<");
      send_byte("!");
      for (i = 0; i < 7; i++) begin
        if (i == bad) send_byte("x");
        else send_byte($urandom_range(0, 1) ? dt[i] - 8'd32 : dt[i]);
      end
      send_str(" html");
      send_byte(">");
    end else begin
      for (i = $urandom_range(1, 6); i > 0; i--) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int p;
    logic [7:0] repl_values [NUM_PHASES];
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'd0;
    cfg_valid   = 1'b0;
    cfg_data    = 8'd0;
    quiet       = 1'b0;
    gap_odds    = 6;
    bytes_sent  = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, with the replacement byte at its reset value.
    send_str("x&<&&y");                   // literal byte after an ampersand
    send_byte(CH_NUL);                    // NUL in text passes unchanged
    send_byte(8'hFF);
    send_str("<1<<A");                    // stray less-than, then a tag
    send_byte(CH_NUL);                    // NUL in a tag name
    send_str(" B");
    send_byte(CH_NUL);                    // NUL in an attribute name
    send_str("=\"v");
    send_byte(CH_NUL);                    // NUL in an attribute value
    send_str("\" c='w'd=e/f g=>");        // quoted values, equals then bracket
    send_str("</>");                      // empty end tag
    send_str("<!-- c --><![CDATA[z]]><?pi?></ 9><!>");
    send_str("<!DocTypE html><!doctyx>"); // doctype match and mismatch
    send_str("<BR/></P/><a / b c\t=x\f>"); // self-closing marks, ignored slash
    send_str("<i x='1'y>");

    // Random phases, each under its own replacement byte; the last one runs without idling.
    repl_values[0] = 8'hFF;
    repl_values[1] = 8'h00;
    repl_values[2] = 8'($urandom_range(1, 254));
    repl_values[3] = htt_pkg::REPL_RESET;
    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_repl(repl_values[p]);
      quiet = (p == NUM_PHASES - 1);
      bytes_sent = 0;
      while (bytes_sent < PHASE_BYTES) send_fragment();
    end

    // Drain everything still expected, then give the verdict.
    in_tvalid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/htt_pkg.sv
hdl/htt_pass.sv
hdl/htt_evq.sv
hdl/html_tag_tokenizer.sv
hdl/htt_chk.sv
test/htt_event_checker.sv
test/html_tag_tokenizer_tb.sv
